// File: design/plsu_pkg.sv
// ----------------------------------------------------------------------------
// plsu_pkg - shared definitions for the literal string unescaper
// Character codes, line-break skip codes and the result entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package plsu_pkg;

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  // what to drop after an escaped line break
  typedef enum logic [1:0] {
    SKIP_NONE = 2'd0,
    SKIP_CR   = 2'd1,
    SKIP_LF   = 2'd2
  } skip_t;

  // octal digit counts
  localparam logic [1:0] OCT_NONE = 2'd0;
  localparam logic [1:0] OCT_ONE  = 2'd1;
  localparam logic [1:0] OCT_FULL = 2'd3;

  // output queue depth (one beat in flight plus two from a new item)
  localparam int unsigned QDEPTH = 3;

  // one result entry
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       eos;
  } res_t;

endpackage

`default_nettype wire

// File: design/pdf_literal_string_unescape.sv
// ----------------------------------------------------------------------------
// pdf_literal_string_unescape - PDF literal string escape decoder
// Turns raw literal string body bytes into unescaped bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw body byte per beat in in_tdata, in_tlast on the final
//           byte of a string.
//   out_* : one decoded byte per beat in out_tdata; out_tuser is 1 when the
//           byte is real, 0 for an empty end marker; out_tlast closes the
//           string.
//   Each input beat yields zero, one or two output beats. Decoding is done
//   in the accept cycle and the results are registered into a three-entry
//   output queue. One input beat is taken every cycle while the queue holds
//   at most one entry; a beat yielding two results fills the queue faster
//   than the single output port drains it.
//   When the receiver stalls the queue fills and in_tready drops; nothing is
//   lost. in_tready depends on registered state only.
//   Reset (synchronous, rst_n low) empties the queue and clears the escape,
//   octal and line-break state.
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_literal_string_unescape (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // last_byte
  // output stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // out_valid
  output logic            out_tlast   // end_of_string
);

  // decoder state
  logic                  esc_r, esc_nxt;
  logic [1:0]            oct_cnt_r, oct_cnt_nxt;
  logic [7:0]            oct_val_r, oct_val_nxt;
  plsu_pkg::skip_t       skip_r, skip_nxt;

  // output queue
  plsu_pkg::res_t        q_r   [plsu_pkg::QDEPTH];
  plsu_pkg::res_t        q_nxt [plsu_pkg::QDEPTH];
  logic [1:0]            cnt_r, cnt_nxt;

  // decode results of the current beat
  plsu_pkg::res_t        r0, r1;
  logic [1:0]            n_res;

  logic                  in_acc, out_acc;

  assign in_tready  = (cnt_r <= 2'd1);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = q_r[0].data;
  assign out_tuser  = q_r[0].vld;
  assign out_tlast  = q_r[0].eos;

  // escape decode for one beat
  always_comb begin
    logic [7:0] c;
    logic       is_oct;
    logic       handled;
    logic [7:0] oct_sum;
    logic [1:0] oct_inc;
    plsu_pkg::res_t e;

    c        = in_tdata;
    is_oct   = (c >= plsu_pkg::CH_ZERO) && (c <= plsu_pkg::CH_SEVEN);
    handled  = 1'b0;
    oct_sum  = {oct_val_r[4:0], 3'b000} + (c - plsu_pkg::CH_ZERO);
    oct_inc  = oct_cnt_r + 2'd1;
    e        = '0;
    r0       = '0;
    r1       = '0;
    n_res    = 2'd0;
    esc_nxt     = esc_r;
    oct_cnt_nxt = oct_cnt_r;
    oct_val_nxt = oct_val_r;
    skip_nxt    = plsu_pkg::SKIP_NONE;

    // drop the partner byte of an escaped line break
    if ((skip_r == plsu_pkg::SKIP_CR && c == plsu_pkg::CH_CR) ||
        (skip_r == plsu_pkg::SKIP_LF && c == plsu_pkg::CH_LF)) begin
      handled = 1'b1;
    end

    // octal gathering in progress
    if (!handled && oct_cnt_r != plsu_pkg::OCT_NONE) begin
      if (is_oct) begin
        handled = 1'b1;
        if (oct_inc == plsu_pkg::OCT_FULL) begin
          r0          = '{data: oct_sum, vld: 1'b1, eos: 1'b0};
          n_res       = 2'd1;
          oct_cnt_nxt = plsu_pkg::OCT_NONE;
          oct_val_nxt = '0;
        end else begin
          oct_cnt_nxt = oct_inc;
          oct_val_nxt = oct_sum;
        end
      end else begin
        r0          = '{data: oct_val_r, vld: 1'b1, eos: 1'b0};
        n_res       = 2'd1;
        oct_cnt_nxt = plsu_pkg::OCT_NONE;
        oct_val_nxt = '0;
      end
    end

    // plain byte or escape successor
    if (!handled) begin
      e.vld = 1'b0;
      if (!esc_r) begin
        if (c == plsu_pkg::CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else begin
          e = '{data: c, vld: 1'b1, eos: 1'b0};
        end
      end else begin
        esc_nxt = 1'b0;
        if (is_oct) begin
          oct_cnt_nxt = plsu_pkg::OCT_ONE;
          oct_val_nxt = c - plsu_pkg::CH_ZERO;
        end else begin
          unique case (c)
            plsu_pkg::CH_N:  e = '{data: plsu_pkg::CH_LF, vld: 1'b1, eos: 1'b0};
            plsu_pkg::CH_R:  e = '{data: plsu_pkg::CH_CR, vld: 1'b1, eos: 1'b0};
            plsu_pkg::CH_T:  e = '{data: plsu_pkg::CH_HT, vld: 1'b1, eos: 1'b0};
            plsu_pkg::CH_B:  e = '{data: plsu_pkg::CH_BS, vld: 1'b1, eos: 1'b0};
            plsu_pkg::CH_F:  e = '{data: plsu_pkg::CH_FF, vld: 1'b1, eos: 1'b0};
            plsu_pkg::CH_LF: skip_nxt = plsu_pkg::SKIP_CR;
            plsu_pkg::CH_CR: skip_nxt = plsu_pkg::SKIP_LF;
            default:         e = '{data: c, vld: 1'b1, eos: 1'b0};
          endcase
        end
      end
      if (e.vld) begin
        if (n_res == 2'd0) begin
          r0 = e;
        end else begin
          r1 = e;
        end
        n_res = n_res + 2'd1;
      end
    end

    // end of string: flush octal, drop backslash, mark last result
    if (in_tlast) begin
      if (oct_cnt_nxt != plsu_pkg::OCT_NONE) begin
        r0    = '{data: oct_val_nxt, vld: 1'b1, eos: 1'b0};
        n_res = 2'd1;
      end
      if (n_res == 2'd0) begin
        r0    = '{data: 8'h00, vld: 1'b0, eos: 1'b1};
        n_res = 2'd1;
      end else if (n_res == 2'd1) begin
        r0.eos = 1'b1;
      end else begin
        r1.eos = 1'b1;
      end
      esc_nxt     = 1'b0;
      oct_cnt_nxt = plsu_pkg::OCT_NONE;
      oct_val_nxt = '0;
      skip_nxt    = plsu_pkg::SKIP_NONE;
    end
  end

  // queue update: pop at the head, append new results behind
  always_comb begin
    logic [1:0] base;
    logic [1:0] push;
    plsu_pkg::res_t shifted;

    push = in_acc ? n_res : 2'd0;
    base = cnt_r - {1'b0, out_acc};
    for (int i = 0; i < plsu_pkg::QDEPTH; i++) begin
      if (out_acc && i < plsu_pkg::QDEPTH - 1) begin
        shifted = q_r[i + 1];
      end else begin
        shifted = q_r[i];
      end
      if (push != 2'd0 && base == 2'(i)) begin
        q_nxt[i] = r0;
      end else if (push == 2'd2 && base + 2'd1 == 2'(i)) begin
        q_nxt[i] = r1;
      end else begin
        q_nxt[i] = shifted;
      end
    end
    cnt_nxt = base + push;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r     <= 1'b0;
      oct_cnt_r <= plsu_pkg::OCT_NONE;
      oct_val_r <= '0;
      skip_r    <= plsu_pkg::SKIP_NONE;
      cnt_r     <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        esc_r     <= esc_nxt;
        oct_cnt_r <= oct_cnt_nxt;
        oct_val_r <= oct_val_nxt;
        skip_r    <= skip_nxt;
      end
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < plsu_pkg::QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_pdf_literal_string_unescape.sv
// ----------------------------------------------------------------------------
// tb_pdf_literal_string_unescape - testbench for the literal string unescaper
// Streams raw string body bytes into the block, predicts the decoded bytes
// with a behavioral unescaper and compares every output beat in order.
// A directed run of escapes, octal codes and line breaks comes first. Random
// strings follow under four idle patterns, one long output hold that fills
// the block, and sender pauses.
// ----------------------------------------------------------------------------
module tb_pdf_literal_string_unescape;

  localparam int CLK_HALF      = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BEATS   = 120;
  localparam int TIMEOUT_TICKS = 12 * 200000;
  localparam int MAX_PRINTS    = 40;

  // one raw input beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // [7:0] in_byte
  logic       in_tlast = 1'b0;   // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic       out_tuser;         // out_valid
  logic       out_tlast;         // end_of_string

  raw_beat_t        pending_raw_q[$];
  plsu_pkg::res_t   decoded_q[$];

  // unescaper state mirrored by the predictor
  logic             esc_pend = 1'b0;
  logic [1:0]       oct_cnt = plsu_pkg::OCT_NONE;
  logic [7:0]       oct_val = 8'h00;
  plsu_pkg::skip_t  brk_skip = plsu_pkg::SKIP_NONE;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int send_idle_tbl[4] = '{0, 47, 0, 29};
  int recv_stall_tbl[4] = '{0, 0, 47, 29};
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  logic rx_hold = 1'b0;

  int err_cnt = 0;
  int n_raw_queued = 0;
  int n_raw_taken = 0;
  int n_decoded_seen = 0;
  int n_strings = 0;

  pdf_literal_string_unescape dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic bit is_octal_digit(input logic [7:0] c);
    return c >= plsu_pkg::CH_ZERO && c <= plsu_pkg::CH_SEVEN;
  endfunction

  function automatic void push_decoded(input logic [7:0] b);
    plsu_pkg::res_t r;
    r.data = b;
    r.vld  = 1'b1;
    r.eos  = 1'b0;
    decoded_q.push_back(r);
  endfunction

  // predict the decoded beats caused by one accepted raw beat
  task automatic unescape_beat(input logic [7:0] c, input logic lst);
    int              base;
    bit              done;
    plsu_pkg::skip_t skip;
    plsu_pkg::res_t  r;
    base = decoded_q.size();
    done = 1'b0;
    // a break escape may swallow its partner byte
    if (brk_skip != plsu_pkg::SKIP_NONE) begin
      skip = brk_skip;
      brk_skip = plsu_pkg::SKIP_NONE;
      if ((skip == plsu_pkg::SKIP_CR && c == plsu_pkg::CH_CR) ||
          (skip == plsu_pkg::SKIP_LF && c == plsu_pkg::CH_LF)) done = 1'b1;
    end
    // octal gathering in progress
    if (!done && oct_cnt != plsu_pkg::OCT_NONE) begin
      if (is_octal_digit(c)) begin
        oct_val = {oct_val[4:0], c[2:0]};
        oct_cnt = oct_cnt + 2'd1;
        if (oct_cnt == plsu_pkg::OCT_FULL) begin
          push_decoded(oct_val);
          oct_cnt = plsu_pkg::OCT_NONE;
          oct_val = 8'h00;
        end
        done = 1'b1;
      end else begin
        push_decoded(oct_val);
        oct_cnt = plsu_pkg::OCT_NONE;
        oct_val = 8'h00;
      end
    end
    // plain byte or escape successor
    if (!done) begin
      if (!esc_pend) begin
        if (c == plsu_pkg::CH_BSLASH) esc_pend = 1'b1;
        else push_decoded(c);
      end else begin
        esc_pend = 1'b0;
        if (is_octal_digit(c)) begin
          oct_cnt = plsu_pkg::OCT_ONE;
          oct_val = {5'd0, c[2:0]};
        end else begin
          case (c)
            plsu_pkg::CH_N: begin
              push_decoded(plsu_pkg::CH_LF);
            end
            plsu_pkg::CH_R: begin
              push_decoded(plsu_pkg::CH_CR);
            end
            plsu_pkg::CH_T: begin
              push_decoded(plsu_pkg::CH_HT);
            end
            plsu_pkg::CH_B: begin
              push_decoded(plsu_pkg::CH_BS);
            end
            plsu_pkg::CH_F: begin
              push_decoded(plsu_pkg::CH_FF);
            end
            plsu_pkg::CH_LF: begin
              brk_skip = plsu_pkg::SKIP_CR;
            end
            plsu_pkg::CH_CR: begin
              brk_skip = plsu_pkg::SKIP_LF;
            end
            default: begin
              push_decoded(c);
            end
          endcase
        end
      end
    end
    // end of string: flush octal, drop backslash, tag the last beat
    if (lst) begin
      if (oct_cnt != plsu_pkg::OCT_NONE) push_decoded(oct_val);
      esc_pend = 1'b0;
      oct_cnt  = plsu_pkg::OCT_NONE;
      oct_val  = 8'h00;
      brk_skip = plsu_pkg::SKIP_NONE;
      if (decoded_q.size() == base) begin
        r = '{data: 8'h00, vld: 1'b0, eos: 1'b1};
      end else begin
        r = decoded_q.pop_back();
        r.eos = 1'b1;
      end
      decoded_q.push_back(r);
      n_strings++;
    end
  endtask

  // input driver: hold each beat until taken, idle at random between beats
  always @(posedge clk) begin
    bit offering;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offering = in_tvalid;
      if (in_tvalid && in_tready) begin
        unescape_beat(in_tdata, in_tlast);
        void'(pending_raw_q.pop_front());
        n_raw_taken++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (pending_raw_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_raw_q[0].data;
          in_tlast  <= pending_raw_q[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin
    plsu_pkg::res_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_decoded_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data=%h user=%b last=%b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          exp_r = decoded_q.pop_front();
          if ({out_tdata, out_tuser, out_tlast} !== {exp_r.data, exp_r.vld, exp_r.eos})
            report_mismatch($sformatf("beat %0d got data=%h user=%b last=%b, want %h %b %b",
                                      n_decoded_seen, out_tdata, out_tuser, out_tlast,
                                      exp_r.data, exp_r.vld, exp_r.eos));
        end
      end
      out_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold, counted here so the sender keeps pushing meanwhile
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
    hold_done = 1'b1;
  end

  function automatic void queue_raw(input logic [7:0] b, input logic lst);
    pending_raw_q.push_back(raw_beat_t'{data: b, last: lst});
    n_raw_queued++;
  endfunction

  // wait until every raw beat is taken and every decoded beat has arrived
  task automatic wait_idle();
    while (pending_raw_q.size() != 0 || decoded_q.size() != 0 || in_tvalid)
      @(negedge clk);
  endtask

  // one random string, mostly well-formed escapes with random content
  task automatic add_random_string();
    logic [7:0] body[$];
    logic [7:0] esc_codes[6];
    int         n_tok;
    int         pick;
    int         t;
    bit         use_cr;
    esc_codes = '{plsu_pkg::CH_N, plsu_pkg::CH_R, plsu_pkg::CH_T, plsu_pkg::CH_B,
                  plsu_pkg::CH_F, plsu_pkg::CH_BSLASH};
    n_tok = $urandom_range(1, 6);
    for (t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        body.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        body.push_back(plsu_pkg::CH_BSLASH);
        body.push_back(esc_codes[$urandom_range(0, 5)]);
      end else if (pick < 65) begin
        body.push_back(plsu_pkg::CH_BSLASH);
        repeat ($urandom_range(1, 3))
          body.push_back(plsu_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
      end else if (pick < 80) begin
        // escaped line break, then its partner, a repeat of itself, or nothing
        use_cr = 1'($urandom_range(0, 1));
        body.push_back(plsu_pkg::CH_BSLASH);
        body.push_back(use_cr ? plsu_pkg::CH_CR : plsu_pkg::CH_LF);
        case ($urandom_range(0, 3))
          0, 1: begin
            body.push_back(use_cr ? plsu_pkg::CH_LF : plsu_pkg::CH_CR);
          end
          2: begin
            body.push_back(use_cr ? plsu_pkg::CH_CR : plsu_pkg::CH_LF);
          end
          default: begin
          end
        endcase
      end else if (pick < 92) begin
        body.push_back(plsu_pkg::CH_BSLASH);
        body.push_back(8'($urandom_range(0, 255)));
      end else begin
        body.push_back(8'($urandom_range(0, 255)));
      end
    end
    // now and then a dangling backslash at the end
    if ($urandom_range(0, 9) == 0) body.push_back(plsu_pkg::CH_BSLASH);
    foreach (body[i]) queue_raw(body[i], i == body.size() - 1);
  endtask

  // stimulus sequence
  initial begin
    int p;
    int target;
    bit paused;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: doubled backslash
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_BSLASH, 1'b0);
    // three octal digits with overflow above eight bits
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_SEVEN, 1'b0);
    queue_raw(plsu_pkg::CH_SEVEN, 1'b0);  queue_raw(plsu_pkg::CH_SEVEN, 1'b0);
    // single octal digit closed by a non-digit that starts a newline escape
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(8'h35, 1'b0);
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_N, 1'b0);
    // remaining letter escapes
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_R, 1'b0);
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_T, 1'b0);
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_B, 1'b0);
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_F, 1'b0);
    // escaped line breaks, each with its partner swallowed
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_LF, 1'b0);
    queue_raw(plsu_pkg::CH_CR, 1'b0);
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_CR, 1'b0);
    queue_raw(plsu_pkg::CH_LF, 1'b0);
    // other escaped byte at the top of the range, plain zero byte ends string
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(8'hFF, 1'b0); queue_raw(8'h00, 1'b1);
    // an escaped backslash closes one string, a bare backslash gives an empty end marker
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(plsu_pkg::CH_BSLASH, 1'b1);
    queue_raw(plsu_pkg::CH_BSLASH, 1'b1);
    // pending octal flushed at end of string
    queue_raw(plsu_pkg::CH_BSLASH, 1'b0); queue_raw(8'h31, 1'b0); queue_raw(8'h32, 1'b1);
    wait_idle();

    // receiver holds off while the sender keeps offering
    hold_go = 1'b1;
    while (n_raw_queued < 75) add_random_string();
    wait (hold_done);
    wait_idle();

    // random strings under each idle pattern, one sender pause per phase
    for (p = 0; p < 4; p++) begin
      send_idle_pct  = send_idle_tbl[p];
      recv_stall_pct = recv_stall_tbl[p];
      target = n_raw_queued + PHASE_BEATS;
      paused = 1'b0;
      while (n_raw_queued < target) begin
        add_random_string();
        if (!paused && n_raw_queued >= target - PHASE_BEATS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("run covered %0d strings: %0d raw beats in, %0d decoded beats out",
             n_strings, n_raw_taken, n_decoded_seen);
    $display("idle patterns none, sender, receiver and both, plus a %0d-cycle output hold",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #TIMEOUT_TICKS;
    $display("timeout with %0d beats queued and %0d results outstanding",
             pending_raw_q.size(), decoded_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
